// ----- design/lph_pkg.sv -----
// Shared types and constants for the tagged linear-probe hash table.
// No dependencies; imported by lph_engine and the top level.
package lph_pkg;

	// SLOT_COUNT is a power of two: the home slot is the low hash bits.
	localparam int SLOT_COUNT   = 1024;
	localparam int IDX_W        = $clog2(SLOT_COUNT);
	localparam int PAYLOAD_BITS = 64;
	localparam int KEY_W        = 64;
	localparam int HASH_W       = 64;
	localparam int PAY_IN_W     = 64;
	localparam int TAG_W        = 8;
	localparam int FP_W         = 7;
	localparam int FP_LSB       = 56;
	localparam int OUT_IDX_W    = 10;
	localparam int KB_W         = 4;
	localparam int STATUS_W     = 2;
	localparam int OP_W         = 2;

	localparam logic [KB_W-1:0]  KEY_BYTES_RST = KB_W'(8);
	localparam logic [FP_W-1:0]  FP_MASK       = '1;

	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
	localparam logic [OP_W-1:0] OP_DISABLE = 2'd1;
	localparam logic [OP_W-1:0] OP_INSERT  = 2'd2;

	localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [KEY_W-1:0]    key;
		logic [HASH_W-1:0]   hash_value;
		logic [PAY_IN_W-1:0] payload;
		logic                write_payload;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [OUT_IDX_W-1:0] slot_index;
		logic [PAY_IN_W-1:0]  slot_payload;
	} res_t;

endpackage

// ----- design/lph_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; instantiated by lph_engine for the tag, key and payload stores.
module lph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- design/lph_engine.sv -----
// Probe engine: sequencer, tag/key/payload stores and the slot compare.
// Depends on lph_pkg and lph_ram.
module lph_engine (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  lph_pkg::req_t           in_req,
	input  logic [lph_pkg::KB_W-1:0] key_bytes,
	output logic                    res_valid,
	input  logic                    res_ready,
	output lph_pkg::res_t           res
);
	import lph_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0]        idx_q, cnt_q, nidx;
	logic [OP_W-1:0]         op_q;
	logic [KEY_W-1:0]        key_q;
	logic [TAG_W-1:0]        target_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic                    wpay_q;
	res_t                    res_q;

	logic [IDX_W-1:0]        rd_addr;
	logic                    tag_we, key_we, pay_we;
	logic [TAG_W-1:0]        tag_wd, tag_rd;
	logic [KEY_W-1:0]        key_rd;
	logic [PAYLOAD_BITS-1:0] pay_rd;
	logic [KEY_W-1:0]        cmask;

	logic is_ins, is_dis, filled, hit, miss, last_clr;
	res_t res_d;

	lph_ram #(.WIDTH(TAG_W), .DEPTH(SLOT_COUNT)) u_tag (
		.clk(clk), .wr_en(tag_we), .wr_addr(idx_q), .wr_data(tag_wd),
		.rd_addr(rd_addr), .rd_data(tag_rd)
	);

	lph_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_COUNT)) u_key (
		.clk(clk), .wr_en(key_we), .wr_addr(idx_q), .wr_data(key_q),
		.rd_addr(rd_addr), .rd_data(key_rd)
	);

	lph_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOT_COUNT)) u_pay (
		.clk(clk), .wr_en(pay_we), .wr_addr(idx_q), .wr_data(pay_q),
		.rd_addr(rd_addr), .rd_data(pay_rd)
	);

	// byte compare mask; key_bytes of 8 or more covers every byte
	always_comb begin
		for (int b = 0; b < KEY_W / 8; b++) begin
			cmask[8*b +: 8] = {8{key_bytes > KB_W'(b)}};
		end
	end

	assign nidx     = (idx_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : idx_q + 1'b1;
	assign last_clr = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign is_ins   = (op_q == OP_INSERT);
	assign is_dis   = (op_q == OP_DISABLE);
	assign filled   = tag_rd[TAG_W-1];
	assign hit      = is_ins ? !filled
		: (filled && tag_rd == target_q && ((key_rd ^ key_q) & cmask) == '0);
	assign miss     = !hit && ((!is_ins && !filled) || cnt_q == IDX_W'(SLOT_COUNT - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (last_clr) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_PROBE;
			ST_PROBE: if (hit || miss) state_d = ST_DONE;
			ST_DONE:  if (res_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		rd_addr   = idx_q;
		tag_we    = 1'b0;
		key_we    = 1'b0;
		pay_we    = 1'b0;
		tag_wd    = '0;
		res_d     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				tag_we = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_req.hash_value[IDX_W-1:0];
			end
			ST_PROBE: begin
				rd_addr = nidx;
				if (hit) begin
					tag_we = is_ins || is_dis;
					tag_wd = is_ins ? target_q : {target_q[TAG_W-1], target_q[FP_W-1:0] ^ FP_MASK};
					key_we = is_ins;
					pay_we = is_ins && wpay_q;
					res_d.status       = STS_OK;
					res_d.slot_index   = OUT_IDX_W'(idx_q);
					res_d.slot_payload = PAY_IN_W'((is_ins && wpay_q) ? pay_q : pay_rd);
				end else begin
					res_d.status = is_ins ? STS_FULL : STS_MISS;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: idx_q <= nidx;
				ST_IDLE: if (in_valid) begin
					idx_q <= in_req.hash_value[IDX_W-1:0];
					cnt_q <= '0;
				end
				ST_PROBE: if (!hit && !miss) begin
					idx_q <= nidx;
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q     <= in_req.op;
			key_q    <= in_req.key;
			target_q <= {1'b1, in_req.hash_value[FP_LSB +: FP_W]};
			pay_q    <= in_req.payload[PAYLOAD_BITS-1:0];
			wpay_q   <= in_req.write_payload;
		end
		if (state_q == ST_PROBE) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// ----- design/tagged_linear_probe_hash_table.sv -----
// Top level of the tagged linear-probe hash table: config register, output register.
// Depends on lph_pkg and lph_engine.
//
// Usage:
//   s_* carries requests: s_tuser = {write_payload, op}, s_tdata = {payload,
//   hash_value, key}. m_* carries one result per request: m_tuser = status,
//   m_tdata = {slot_payload, slot_index}. cfg_* writes key_bytes; write it
//   only while no request is in flight.
//   A request visits 1 to 1024 slots, one slot read per cycle from the tag,
//   key and payload memories. The engine then holds the result in its done
//   state until it is handed off, and takes the next request only in its
//   idle state.
//   After reset the tag memory is cleared one slot per cycle; s_tready stays
//   low until every slot is cleared. key_bytes resets to 8.
//   If the receiver stalls, the result waits in the output register while the
//   engine takes and works the next request; that request's result waits in
//   the engine until the output register frees.
module tagged_linear_probe_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [191:0] s_tdata,  // key[63:0], hash_value[127:64], payload[191:128]
	input  logic [2:0]  s_tuser,   // op[1:0], write_payload[2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // slot_index[9:0], slot_payload[73:10], zero pad
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);
	import lph_pkg::*;

	logic [KB_W-1:0] key_bytes_q;
	req_t            req;
	res_t            res;
	logic            res_valid, res_ready;
	logic            m_valid_q;
	res_t            m_res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q <= KEY_BYTES_RST;
		end else if (cfg_valid) begin
			key_bytes_q <= cfg_data;
		end
	end

	assign req.op            = s_tuser[1:0];
	assign req.write_payload = s_tuser[2];
	assign req.key           = s_tdata[63:0];
	assign req.hash_value    = s_tdata[127:64];
	assign req.payload       = s_tdata[191:128];

	lph_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_req(req),
		.key_bytes(key_bytes_q),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {6'd0, m_res_q.slot_payload, m_res_q.slot_index};

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STS_OK) |-> (m_tdata == '0))
		else $error("miss or full result carries slot data");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res)))
		else $error("engine result dropped while output register busy");

endmodule
